/* rtl/ordered_list_engine_macros.svh */
// Assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLE_ASSERT(label, clk, rst, prop, msg)
`define OLE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/ole_pkg.sv */
package ole_pkg;
  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_INSERT    = 4'd1;
  localparam logic [3:0] OP_APPEND    = 4'd2;
  localparam logic [3:0] OP_PREPEND   = 4'd3;
  localparam logic [3:0] OP_DEL_KEY   = 4'd4;
  localparam logic [3:0] OP_DEL_LAST  = 4'd5;
  localparam logic [3:0] OP_DEL_FIRST = 4'd6;
  localparam logic [3:0] OP_REVERSE   = 4'd7;
  localparam logic [3:0] OP_DUMP      = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture operation and key
    logic       edit;      // apply the held operation to the cells
    logic       dump_init; // start a dump at the head
    logic       dump_step; // advance dump position
    logic       emit;      // load output register
  } ole_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dump;
    logic empty;
    logic dump_end;   // position at last key
  } ole_stat_t;
endpackage

/* rtl/ole_if.sv */
interface ole_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic signed [31:0] key_value;
  modport source (output valid, operation, key_value, input ready);
  modport sink   (input valid, operation, key_value, output ready);
endinterface

interface ole_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  entry_count;
  logic signed [31:0] out_key;
  logic [4:0]  position;
  logic        last;
  modport source (output valid, status, entry_count, out_key, position, last,
                  input ready);
  modport sink   (input valid, status, entry_count, out_key, position, last,
                  output ready);
endinterface

/* rtl/ordered_list_engine.sv */
// Ordered list engine: shift-register cells with parallel compare.
// An edit is captured, then applied to the cells as its result word is loaded.
// A dump is captured, starts at the head, then gives its result words in order (one word when empty).
// Each result cycle waits while the output word is held back by the receiver.
// Synchronous active-high reset empties the list; cell contents are not cleared.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input logic clk,
  input logic rst,
  ole_in_if.sink    in_ch,
  ole_out_if.source out_ch
);
  ole_cmd_t  cmd;
  ole_stat_t stat;

  ole_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  ole_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .in_op(in_ch.operation), .in_key(in_ch.key_value),
    .cmd(cmd), .stat(stat),
    .res_status(out_ch.status), .res_count(out_ch.entry_count),
    .res_key(out_ch.out_key), .res_pos(out_ch.position), .res_last(out_ch.last)
  );
endmodule

/* rtl/ole_datapath.sv */
module ole_datapath
  import ole_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic [3:0] in_op,
  input  logic signed [31:0] in_key,
  input  ole_cmd_t  cmd,
  output ole_stat_t stat,
  output logic [1:0]  res_status,
  output logic [5:0]  res_count,
  output logic signed [31:0] res_key,
  output logic [4:0]  res_pos,
  output logic        res_last
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [31:0] cells [CAPACITY];
  logic signed [31:0] cells_next [CAPACITY];
  logic [CW-1:0] count, count_next;
  logic [3:0]  op;
  logic signed [31:0] key;
  logic [IW-1:0] dpos;
  logic [1:0]  status_next;
  logic [CAPACITY-1:0] ge_hit, eq_hit, ins_mask, del_mask, live;
  logic [CAPACITY-1:0] ins_pre, del_pre;

  // parallel compares over live cells
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]   = CW'(i) < count;
      ge_hit[i] = live[i] && (cells[i] >= key);
      eq_hit[i] = live[i] && (cells[i] == key);
    end
  end

  // prefix of first hit: bit i set when a hit (for insert, also a free cell) lies at or below i
  always_comb begin
    ins_pre[0] = ge_hit[0] | ~live[0];
    del_pre[0] = eq_hit[0];
    for (int i = 1; i < CAPACITY; i++) begin
      ins_pre[i] = ins_pre[i-1] | ge_hit[i] | ~live[i];
      del_pre[i] = del_pre[i-1] | eq_hit[i];
    end
    ins_mask = ins_pre;
    del_mask = del_pre;
  end

  // next cells and count
  always_comb begin
    logic full, empty;
    logic [CAPACITY-1:0] sh;
    full = count >= CW'(CAPACITY);
    empty = count == '0;
    sh = '0;
    for (int i = 0; i < CAPACITY; i++) cells_next[i] = cells[i];
    count_next = count;
    status_next = ST_OK;
    case (op) inside
      OP_CLEAR: count_next = '0;
      OP_INSERT, OP_APPEND, OP_PREPEND: begin
        if (full) status_next = ST_FULL;
        else begin
          if (op == OP_INSERT) sh = ins_mask;
          else if (op == OP_PREPEND) sh = '1;
          else sh = ~live;
          for (int i = 0; i < CAPACITY; i++)
            if (sh[i]) cells_next[i] = (i == 0 || !sh[i-1 < 0 ? 0 : i-1]) ? key
                                       : cells[i-1];
          count_next = count + 1'b1;
        end
      end
      OP_DEL_KEY: begin
        if (empty) status_next = ST_EMPTY;
        else if (!del_mask[CAPACITY-1]) status_next = ST_NOTFOUND;
        else begin
          for (int i = 0; i < CAPACITY - 1; i++)
            if (del_mask[i]) cells_next[i] = cells[i+1];
          count_next = count - 1'b1;
        end
      end
      OP_DEL_LAST: begin
        if (empty) status_next = ST_EMPTY;
        else count_next = count - 1'b1;
      end
      OP_DEL_FIRST: begin
        if (empty) status_next = ST_EMPTY;
        else begin
          for (int i = 0; i < CAPACITY - 1; i++) cells_next[i] = cells[i+1];
          count_next = count - 1'b1;
        end
      end
      OP_REVERSE: begin
        if (empty) status_next = ST_EMPTY;
        else begin
          for (int i = 0; i < CAPACITY; i++)
            if (live[i]) cells_next[i] = cells[IW'(count - CW'(1) - CW'(i))];
        end
      end
      default: ;
    endcase
  end

  assign stat.is_dump  = op == OP_DUMP;
  assign stat.empty    = count == '0;
  assign stat.dump_end = CW'(dpos) + CW'(1) >= count;

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      key <= in_key;
    end
    if (cmd.edit) begin
      for (int i = 0; i < CAPACITY; i++) cells[i] <= cells_next[i];
    end
    if (rst) count <= '0;
    else if (cmd.edit) count <= count_next;
    if (cmd.dump_init) dpos <= '0;
    else if (cmd.dump_step) dpos <= dpos + 1'b1;
    if (cmd.emit) begin
      res_count <= 6'(count_next);
      if (op == OP_DUMP) begin
        res_status <= stat.empty ? ST_EMPTY : ST_OK;
        res_key    <= stat.empty ? '0 : cells[dpos];
        res_pos    <= stat.empty ? '0 : 5'(dpos);
        res_last   <= stat.empty | stat.dump_end;
      end else begin
        res_status <= status_next;
        res_key    <= '0;
        res_pos    <= '0;
        res_last   <= 1'b1;
      end
    end
  end
endmodule

/* rtl/ole_ctrl.sv */
module ole_ctrl
  import ole_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ole_stat_t stat,
  output ole_cmd_t  cmd
);
`include "ordered_list_engine_macros.svh"
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state, state_next;
  logic out_free;
  logic dump_more; // held low and never set here, so it never blocks in_ready

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !dump_more;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_EXEC;
      S_EXEC: begin
        if (stat.is_dump) begin
          cmd.dump_init = 1'b1;
          state_next = S_DUMP;
        end else if (out_free) begin
          cmd.edit = 1'b1;
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: if (out_free) begin
        cmd.emit = 1'b1;
        cmd.dump_step = 1'b1;
        if (stat.empty || stat.dump_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dump_more <= 1'b0;
    end else begin
      state <= state_next;
      dump_more <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `OLE_ASSERT(a_emit_free, clk, rst, cmd.emit |-> out_free, "emit over held word")
  `OLE_ASSERT(a_no_load_busy, clk, rst, cmd.load |-> state == S_IDLE, "load while busy")
  `OLE_ASSERT(a_exec_follows, clk, rst, cmd.load |=> state == S_EXEC, "load not executed")
endmodule

/* tb/ole_list_checker.sv */
// Watches both channels of the list engine, keeps its own copy of the list
// and compares every result word with the oldest expected one.
module ole_list_checker
  import ole_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  ole_in_if    mon_in,
  ole_out_if   mon_out,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   full_seen
);

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         entry_count;
    logic signed [31:0] out_key;
    logic [4:0]         position;
    logic               last;
  } list_result_t;

  logic signed [31:0] keys_held[$];
  list_result_t       result_q[$];

  initial begin
    errors    = 0;
    pending   = 0;
    checked   = 0;
    full_seen = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic list_result_t status_word(input logic [1:0] st);
    list_result_t r;
    r.status      = st;
    r.entry_count = 6'(keys_held.size());
    r.out_key     = '0;
    r.position    = '0;
    r.last        = 1'b1;
    return r;
  endfunction

  // apply one operation to the copy of the list and queue its results
  task automatic apply_operation(input logic [3:0] op, input logic signed [31:0] key);
    logic [1:0]         st;
    int                 i;
    int                 n;
    list_result_t       r;
    logic signed [31:0] flipped[$];
    st = ST_OK;
    n  = keys_held.size();
    case (op)
      OP_CLEAR: keys_held.delete();
      OP_INSERT, OP_APPEND, OP_PREPEND: begin
        if (n >= CAPACITY) begin
          st = ST_FULL;
        end else if (op == OP_INSERT) begin
          i = 0;
          while (i < n && !(keys_held[i] >= key)) i++;
          keys_held.insert(i, key);
        end else if (op == OP_APPEND) begin
          keys_held.push_back(key);
        end else begin
          keys_held.push_front(key);
        end
      end
      OP_DEL_KEY: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          i = 0;
          while (i < n && keys_held[i] != key) i++;
          if (i < n) keys_held.delete(i);
          else st = ST_NOTFOUND;
        end
      end
      OP_DEL_LAST: begin
        if (n == 0) st = ST_EMPTY;
        else void'(keys_held.pop_back());
      end
      OP_DEL_FIRST: begin
        if (n == 0) st = ST_EMPTY;
        else void'(keys_held.pop_front());
      end
      OP_REVERSE: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          foreach (keys_held[j]) flipped.push_front(keys_held[j]);
          keys_held = flipped;
        end
      end
      OP_DUMP: begin
        if (n == 0) begin
          result_q.push_back(status_word(ST_EMPTY));
        end else begin
          for (i = 0; i < n; i++) begin
            r.status      = ST_OK;
            r.entry_count = 6'(n);
            r.out_key     = keys_held[i];
            r.position    = 5'(i);
            r.last        = (i == n - 1);
            result_q.push_back(r);
          end
        end
        return;
      end
      default: ;
    endcase
    result_q.push_back(status_word(st));
  endtask

  // compare first, then predict: a word accepted now cannot answer itself
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (mon_out.valid && mon_out.ready) begin
        if (result_q.size() == 0) begin
          $display("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (mon_out.status != want.status) report("status", mon_out.status, want.status);
          if (mon_out.entry_count != want.entry_count)
            report("entry_count", mon_out.entry_count, want.entry_count);
          if (mon_out.out_key != want.out_key) report("out_key", mon_out.out_key, want.out_key);
          if (mon_out.position != want.position)
            report("position", mon_out.position, want.position);
          if (mon_out.last != want.last) report("last", mon_out.last, want.last);
          if (want.status == ST_FULL) full_seen++;
          checked++;
        end
      end
      if (mon_in.valid && mon_in.ready) apply_operation(mon_in.operation, mon_in.key_value);
      pending = result_q.size();
    end
  end

endmodule

/* tb/tb_ordered_list_engine.sv */
module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int          CAPACITY   = 32;
  localparam logic [3:0]  OP_SPARE_LO = 4'd9;
  localparam logic [3:0]  OP_SPARE_HI = 4'd15;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   checked;
  int   full_seen;
  int   words_sent;
  bit   hold_request;
  int   idle_cycles;

  ole_in_if  in_ch ();
  ole_out_if out_ch ();

  ordered_list_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  ole_list_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk(clk), .rst(rst), .mon_in(in_ch), .mon_out(out_ch),
    .errors(errors), .pending(pending), .checked(checked), .full_seen(full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one word and hold it until taken
  task automatic send(input logic [3:0] op, input logic signed [31:0] key);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_value <= key;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // fill-leaning or drain-leaning mix of operations
  function automatic logic [3:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return (r == 0) ? OP_CLEAR : (r == 1 ? OP_SPARE_LO : OP_SPARE_HI);
    if (r < 12) return OP_DUMP;
    if (r < 16) return OP_REVERSE;
    if (filling) begin
      if (r < 50) return OP_INSERT;
      if (r < 72) return OP_APPEND;
      if (r < 92) return OP_PREPEND;
      return OP_DEL_KEY;
    end
    if (r < 50) return OP_DEL_KEY;
    if (r < 65) return OP_DEL_LAST;
    if (r < 80) return OP_DEL_FIRST;
    return OP_INSERT;
  endfunction

  // receiver: random stalls, clean stretches, one long hold-off
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end
      if (words_sent % 64 < 16) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ordered_list_engine NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    int burst;
    int gap;
    bit filling;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.key_value <= '0;
    words_sent      = 0;
    hold_request    = 1'b0;
    idle_cycles     = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list cases, extreme keys, every operation
    send(OP_DUMP, 0);
    send(OP_DEL_KEY, 5);
    send(OP_DEL_LAST, 0);
    send(OP_DEL_FIRST, 0);
    send(OP_REVERSE, 0);
    send(OP_INSERT, 0);
    send(OP_INSERT, 32'sh8000_0000);
    send(OP_INSERT, 32'sh7fff_ffff);
    send(OP_INSERT, -1);
    send(OP_INSERT, 0);
    send(OP_APPEND, 5);
    send(OP_PREPEND, 7);
    send(OP_DUMP, 0);
    send(OP_DEL_KEY, 12345);
    send(OP_DEL_KEY, 0);
    send(OP_REVERSE, 0);
    send(OP_DUMP, 0);
    send(OP_DEL_LAST, 0);
    send(OP_DEL_FIRST, 0);
    send(OP_SPARE_LO, -1);
    send(OP_SPARE_HI, 32'sh7fff_ffff);
    send(OP_CLEAR, 0);
    send(OP_DUMP, 0);

    // random: alternating fill and drain phases, bursts with gaps
    n = 0;
    while (n < 230) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n < 230) begin
        filling = ((n / 60) % 2) == 0;
        if (n == 100) hold_request = 1'b1;
        send(pick_op(filling), pick_key());
        n++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // let the checker see the last accepted word before draining
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 20) @(posedge clk);

    $display("sent %0d words across fill and drain phases, with one long output hold-off",
             words_sent);
    $display("checked %0d result words, %0d of them full-list refusals", checked, full_seen);
    if (errors == 0 && pending == 0)
      $display("tb_ordered_list_engine OK");
    else
      $display("tb_ordered_list_engine NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_if.sv
rtl/ole_datapath.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine.sv
tb/ole_list_checker.sv
tb/tb_ordered_list_engine.sv
